FILE: src/sorted_chunk_table_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted chunk table
// Clocked on clk, switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_CHUNK_TABLE_DEFINES_SVH
`define SORTED_CHUNK_TABLE_DEFINES_SVH

// Property checked at every rising edge outside reset
`define SCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must hold in one named state
`define SCT_ASSERT_IN(lbl, st, prop, msg) \
  `SCT_ASSERT(lbl, (state_r == st) |-> (prop), msg)

`endif

FILE: src/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Types and constants for the sorted chunk table.
// ----------------------------------------------------------------------------
`default_nettype none
package sct_pkg;
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W      = 32;
  localparam int SIZE_W      = 32;
  localparam int CMD_W       = 2;
  localparam int STAT_W      = 2;
  localparam int IN_W        = 72;
  localparam int OUT_W       = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_MERGE  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_FND_RD, S_FND_CMP, S_REM_RD, S_REM_WR,
    S_MRG_LD, S_MRG_CMP, S_MRG_FIN, S_RESP
  } state_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] start;
  } entry_t;
endpackage
`default_nettype wire

FILE: src/sorted_chunk_table.sv
// Insert shifts larger entries up to make room, find examines entries in order, remove
// moves the later entries down, and merge walks every entry once.
// One command is taken at a time; the simple dual-port entry RAM gives one read and
// one write per cycle.
// A reply held by out_tready stalls the next reply in S_RESP, not the next command.
// Reset: synchronous active-low; clears the entry count and handshake state.
// RAM contents are not cleared; only entries below the count are read.
// ----------------------------------------------------------------------------
// sorted_chunk_table
// Address-ordered chunk table with insert, find, remove and merge commands.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_chunk_table_defines.svh"
module sorted_chunk_table (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output      logic                    in_tready,
  // command[1:0], chunk_start[33:2], chunk_size[65:34], entry_index[71:66]
  input  wire logic [sct_pkg::IN_W-1:0] in_tdata,
  output      logic                    out_tvalid,
  input  wire logic                    out_tready,
  // status[1:0], found_index[7:2], entry_count[14:8], zero[15]
  output      logic [sct_pkg::OUT_W-1:0] out_tdata
);
  import sct_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_r;

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] start_r, start_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt, w_r, w_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  entry_t cur_r, cur_nxt;
  status_t res_stat_r, res_stat_nxt;
  logic [IDX_W-1:0]  res_found_r, res_found_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  logic             mem_we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata;

  logic [ADDR_W-1:0] gap;
  logic [SIZE_W:0]   sum;
  logic              touch;
  logic [CNT_W-1:0]  k_inc;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // merge test against the running chunk
  assign gap   = rd_r.start - cur_r.start;
  assign sum   = {1'b0, cur_r.size} + {1'b0, rd_r.size};
  assign touch = (rd_r.start >= cur_r.start) && (gap == cur_r.size) && !sum[SIZE_W];
  assign k_inc = {1'b0, k_r} + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    start_r     <= start_nxt;
    size_r      <= size_nxt;
    k_r         <= k_nxt;
    w_r         <= w_nxt;
    cur_r       <= cur_nxt;
    res_stat_r  <= res_stat_nxt;
    res_found_r <= res_found_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    start_nxt     = start_r;
    size_nxt      = size_r;
    k_nxt         = k_r;
    w_nxt         = w_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    res_stat_nxt  = res_stat_r;
    res_found_nxt = res_found_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mem_we        = 1'b0;
    waddr         = k_r;
    wdata         = rd_r;
    raddr         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          start_nxt     = in_tdata[33:2];
          size_nxt      = in_tdata[65:34];
          res_stat_nxt  = ST_OK;
          res_found_nxt = '0;
          state_nxt     = S_RESP;
          unique case (cmd_t'(in_tdata[1:0]))
            CMD_INSERT: begin
              if (count_r == CNT_W'(TABLE_DEPTH)) begin
                res_stat_nxt = ST_FULL;
              end else begin
                k_nxt     = count_r[IDX_W-1:0];
                state_nxt = S_INS_RD;
              end
            end
            CMD_FIND: begin
              if (count_r == '0) begin
                res_stat_nxt = ST_NOT_FOUND;
              end else begin
                k_nxt     = '0;
                state_nxt = S_FND_RD;
              end
            end
            CMD_REMOVE: begin
              if ({1'b0, in_tdata[71:66]} >= count_r) begin
                res_stat_nxt = ST_RANGE;
              end else begin
                k_nxt     = in_tdata[71:66];
                state_nxt = S_REM_RD;
              end
            end
            default: begin
              // entry 0 is read on this edge for the merge walk
              if (count_r >= CNT_W'(2)) begin
                state_nxt = S_MRG_LD;
              end
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (k_r == '0) begin
          mem_we    = 1'b1;
          wdata     = '{size: size_r, start: start_r};
          count_nxt = count_r + CNT_W'(1);
          state_nxt = S_RESP;
        end else begin
          raddr     = k_r - IDX_W'(1);
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (start_r < rd_r.start) begin
          k_nxt     = k_r - IDX_W'(1);
          state_nxt = S_INS_RD;
        end else begin
          wdata     = '{size: size_r, start: start_r};
          count_nxt = count_r + CNT_W'(1);
          state_nxt = S_RESP;
        end
      end
      S_FND_RD: begin
        raddr     = k_r;
        state_nxt = S_FND_CMP;
      end
      S_FND_CMP: begin
        if (rd_r.start == start_r) begin
          res_found_nxt = k_r;
          state_nxt     = S_RESP;
        end else if (k_inc == count_r) begin
          res_stat_nxt = ST_NOT_FOUND;
          state_nxt    = S_RESP;
        end else begin
          k_nxt     = k_r + IDX_W'(1);
          state_nxt = S_FND_RD;
        end
      end
      S_REM_RD: begin
        if (k_inc == count_r) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_RESP;
        end else begin
          raddr     = k_r + IDX_W'(1);
          state_nxt = S_REM_WR;
        end
      end
      S_REM_WR: begin
        mem_we    = 1'b1;
        k_nxt     = k_r + IDX_W'(1);
        state_nxt = S_REM_RD;
      end
      S_MRG_LD: begin
        cur_nxt   = rd_r;
        w_nxt     = '0;
        k_nxt     = IDX_W'(1);
        raddr     = IDX_W'(1);
        state_nxt = S_MRG_CMP;
      end
      S_MRG_CMP: begin
        // compaction: w trails k, so writes never hit the entry being read
        if (touch) begin
          cur_nxt.size = sum[SIZE_W-1:0];
        end else begin
          mem_we  = 1'b1;
          waddr   = w_r;
          wdata   = cur_r;
          w_nxt   = w_r + IDX_W'(1);
          cur_nxt = rd_r;
        end
        if (k_inc == count_r) begin
          state_nxt = S_MRG_FIN;
        end else begin
          k_nxt = k_r + IDX_W'(1);
          raddr = k_r + IDX_W'(1);
        end
      end
      S_MRG_FIN: begin
        mem_we    = 1'b1;
        waddr     = w_r;
        wdata     = cur_r;
        count_nxt = {1'b0, w_r} + CNT_W'(1);
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, count_r, res_found_r, res_stat_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `SCT_ASSERT(a_count_bound, count_r <= CNT_W'(TABLE_DEPTH), "entry count above depth")
  `SCT_ASSERT_IN(a_find_no_write, S_FND_CMP, !mem_we, "write during find")
  `SCT_ASSERT_IN(a_merge_order, S_MRG_CMP, w_r < k_r, "merge write pointer not behind read")
  `SCT_ASSERT(a_resp_src, $rose(out_valid_r) |-> $past(state_r == S_RESP), "result not from reply state")
  `SCT_ASSERT(a_ins_addr, (mem_we && (state_r == S_INS_CMP || state_r == S_INS_RD)) |-> ({1'b0, waddr} <= count_r), "insert write beyond count")
endmodule
`default_nettype wire
